// File: sv/rc4_pkg.sv
package rc4_pkg;

    localparam int KEY_DEPTH_DEF = 256;
    localparam int SBOX_DEPTH    = 256;
    localparam int BYTE_W        = 8;
    localparam int LEN_W         = 9;
    localparam int CMD_W         = 2;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QA_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LEN_W-1:0] KEY_LEN_RST = LEN_W'(256);
    localparam logic [BYTE_W-1:0] SBOX_LAST  = BYTE_W'(SBOX_DEPTH - 1);

    localparam logic [CMD_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] OP_BEGIN = 2'd1;
    localparam logic [CMD_W-1:0] OP_CRYPT = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  op;
        logic [BYTE_W-1:0] key_index;
        logic [BYTE_W-1:0] data;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_queue;

endpackage

// File: sv/rc4_stream_cipher.sv
// RC4 byte cipher on a stream interface. The beat kind on s_axis_tuser selects: load one key
// byte, begin a message (sbox fill, then a key schedule that reads s[i] and s[j] and writes
// both halves of the swap for each sbox entry), or crypt one byte (paced by the dependent
// reads and the two swap writes through the one write port of the sbox RAM). A two-beat
// queue ahead of the engine takes input while it works; a crypt result waits in the output
// register. Unused kinds are dropped. Write i_cfg_wdata (key length, 0 acts as 1, saturates
// at KEY_DEPTH) only while the block is idle.
module rc4_stream_cipher #(
    parameter int KEY_DEPTH = rc4_pkg::KEY_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [2*rc4_pkg::BYTE_W-1:0]      s_axis_tdata,   // key_index, data_byte
    input  logic [rc4_pkg::CMD_W-1:0]         s_axis_tuser,   // cmd
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [rc4_pkg::BYTE_W-1:0]        m_axis_tdata,   // out_byte
    input  logic                              i_cfg_we,
    input  logic [rc4_pkg::LEN_W-1:0]         i_cfg_wdata
);
    import rc4_pkg::*;

    t_queue q;
    logic   pop;

    rc4_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_q           (q),
        .i_pop         (pop)
    );

    rc4_back #(.KEY_DEPTH(KEY_DEPTH)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q           (q),
        .o_pop         (pop),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// File: sv/rc4_ram.sv
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/rc4_front.sv
module rc4_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [2*rc4_pkg::BYTE_W-1:0]          s_axis_tdata,
    input  logic [rc4_pkg::CMD_W-1:0]             s_axis_tuser,
    output rc4_pkg::t_queue                       o_q,
    input  logic                                  i_pop
);
    import rc4_pkg::*;

    t_entry            r_mem [QUEUE_DEPTH];
    logic [QA_W-1:0]   r_wptr, n_wptr;
    logic [QA_W-1:0]   r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              known_cmd;
    logic              push;
    t_entry            in_entry;

    assign known_cmd = (s_axis_tuser == OP_LOAD) || (s_axis_tuser == OP_BEGIN)
                    || (s_axis_tuser == OP_CRYPT);
    assign s_axis_tready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign push = s_axis_tvalid && s_axis_tready && known_cmd;

    assign in_entry.op        = s_axis_tuser;
    assign in_entry.key_index = s_axis_tdata[BYTE_W-1:0];
    assign in_entry.data      = s_axis_tdata[2*BYTE_W-1:BYTE_W];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (push) begin
            n_wptr = (r_wptr == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + QA_W'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + QA_W'(1);
        end
        if (push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= in_entry;
        end
    end

    assign o_q.valid = (r_count != '0);
    assign o_q.entry = r_mem[r_rptr];

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !i_pop |=> r_count == $past(r_count) + QCNT_W'(1))
        else $error("queue count did not advance on push");
`endif

endmodule

// File: sv/rc4_back.sv
module rc4_back #(
    parameter int KEY_DEPTH = rc4_pkg::KEY_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rc4_pkg::t_queue               i_q,
    output logic                          o_pop,
    input  logic                          i_cfg_we,
    input  logic [rc4_pkg::LEN_W-1:0]     i_cfg_wdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [rc4_pkg::BYTE_W-1:0]    m_axis_tdata
);
    import rc4_pkg::*;

    localparam int KA_W = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_INIT   = 4'd1;
    localparam logic [3:0] ST_KS_RDI = 4'd2;
    localparam logic [3:0] ST_KS_RDJ = 4'd3;
    localparam logic [3:0] ST_KS_SW1 = 4'd4;
    localparam logic [3:0] ST_KS_SW2 = 4'd5;
    localparam logic [3:0] ST_CR_RDJ = 4'd6;
    localparam logic [3:0] ST_CR_SW1 = 4'd7;
    localparam logic [3:0] ST_CR_SW2 = 4'd8;
    localparam logic [3:0] ST_CR_OUT = 4'd9;

    logic [3:0]        r_state, n_state;
    logic [BYTE_W-1:0] r_n, n_n;
    logic [KA_W-1:0]   r_kpos, n_kpos;
    logic [BYTE_W-1:0] r_i, n_i;
    logic [BYTE_W-1:0] r_j, n_j;
    logic [BYTE_W-1:0] r_si, n_si;
    logic [BYTE_W-1:0] r_sj, n_sj;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic              r_byp, n_byp;
    logic [BYTE_W-1:0] r_data, n_data;
    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_data, n_out_data;
    logic [LEN_W-1:0]  r_key_length, n_key_length;

    logic [LEN_W-1:0]  eff_len;
    logic [BYTE_W-1:0] j_new;
    logic [BYTE_W-1:0] sum;

    logic              sbox_we;
    logic [BYTE_W-1:0] sbox_waddr, sbox_wdata, sbox_raddr, sbox_rdata;
    logic              key_we;
    logic [KA_W-1:0]   key_raddr;
    logic [BYTE_W-1:0] key_rdata;

    rc4_ram #(.WIDTH(BYTE_W), .DEPTH(SBOX_DEPTH)) u_sbox (
        .i_clk   (i_clk),
        .i_we    (sbox_we),
        .i_waddr (sbox_waddr),
        .i_wdata (sbox_wdata),
        .i_raddr (sbox_raddr),
        .o_rdata (sbox_rdata)
    );

    rc4_ram #(.WIDTH(BYTE_W), .DEPTH(KEY_DEPTH)) u_key (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (i_q.entry.key_index[KA_W-1:0]),
        .i_wdata (i_q.entry.data),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    always_comb begin
        if (r_key_length == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_key_length > LEN_W'(KEY_DEPTH)) begin
            eff_len = LEN_W'(KEY_DEPTH);
        end else begin
            eff_len = r_key_length;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_n          = r_n;
        n_kpos       = r_kpos;
        n_i          = r_i;
        n_j          = r_j;
        n_si         = r_si;
        n_sj         = r_sj;
        n_sum        = r_sum;
        n_byp        = r_byp;
        n_data       = r_data;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_data   = r_out_data;
        n_key_length = i_cfg_we ? i_cfg_wdata : r_key_length;
        sbox_we      = 1'b0;
        sbox_waddr   = r_n;
        sbox_wdata   = r_n;
        sbox_raddr   = r_sum;
        key_we       = 1'b0;
        key_raddr    = r_kpos;
        o_pop        = 1'b0;
        j_new        = r_j + sbox_rdata;
        sum          = r_si + r_sj;
        case (r_state)
            ST_IDLE: begin
                if (i_q.valid) begin
                    o_pop = 1'b1;
                    case (i_q.entry.op)
                        OP_LOAD: begin
                            key_we = ({1'b0, i_q.entry.key_index} < LEN_W'(KEY_DEPTH));
                        end
                        OP_BEGIN: begin
                            n_n     = '0;
                            n_state = ST_INIT;
                        end
                        OP_CRYPT: begin
                            n_i        = r_i + BYTE_W'(1);
                            sbox_raddr = r_i + BYTE_W'(1);
                            n_data     = i_q.entry.data;
                            n_state    = ST_CR_RDJ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_INIT: begin
                sbox_we = 1'b1;
                n_n     = r_n + BYTE_W'(1);
                if (r_n == SBOX_LAST) begin
                    n_j     = '0;
                    n_kpos  = '0;
                    n_state = ST_KS_RDI;
                end
            end
            ST_KS_RDI: begin
                sbox_raddr = r_n;
                n_state    = ST_KS_RDJ;
            end
            ST_KS_RDJ: begin
                j_new      = r_j + sbox_rdata + key_rdata;
                n_j        = j_new;
                n_si       = sbox_rdata;
                sbox_raddr = j_new;
                n_state    = ST_KS_SW1;
            end
            ST_KS_SW1: begin
                sbox_we    = 1'b1;
                sbox_wdata = sbox_rdata;
                n_state    = ST_KS_SW2;
            end
            ST_KS_SW2: begin
                sbox_we    = 1'b1;
                sbox_waddr = r_j;
                sbox_wdata = r_si;
                n_n        = r_n + BYTE_W'(1);
                if (LEN_W'(r_kpos) + LEN_W'(1) >= eff_len) begin
                    n_kpos = '0;
                end else begin
                    n_kpos = r_kpos + KA_W'(1);
                end
                if (r_n == SBOX_LAST) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_KS_RDI;
                end
            end
            ST_CR_RDJ: begin
                n_j        = j_new;
                n_si       = sbox_rdata;
                sbox_raddr = j_new;
                n_state    = ST_CR_SW1;
            end
            ST_CR_SW1: begin
                sbox_we    = 1'b1;
                sbox_waddr = r_i;
                sbox_wdata = sbox_rdata;
                n_sj       = sbox_rdata;
                n_state    = ST_CR_SW2;
            end
            ST_CR_SW2: begin
                sbox_we    = 1'b1;
                sbox_waddr = r_j;
                sbox_wdata = r_si;
                sbox_raddr = sum;
                n_sum      = sum;
                n_byp      = (sum == r_j);
                n_state    = ST_CR_OUT;
            end
            ST_CR_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_data ^ (r_byp ? r_si : sbox_rdata);
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_i          <= '0;
            r_j          <= '0;
            r_out_valid  <= 1'b0;
            r_key_length <= KEY_LEN_RST;
        end else begin
            r_state      <= n_state;
            r_i          <= n_i;
            r_j          <= n_j;
            r_out_valid  <= n_out_valid;
            r_key_length <= n_key_length;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_kpos     <= n_kpos;
        r_si       <= n_si;
        r_sj       <= n_sj;
        r_sum      <= n_sum;
        r_byp      <= n_byp;
        r_data     <= n_data;
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_result_from_crypt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_CR_OUT)
        else $error("result raised outside crypt completion");
    a_idle_no_sbox_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> !sbox_we)
        else $error("sbox written while idle");
    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == ST_IDLE)
        else $error("queue popped while busy");
    a_begin_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_q.entry.op == OP_BEGIN |=> r_state == ST_INIT)
        else $error("begin did not start sbox fill");
`endif

endmodule

// File: tb/tb_rc4_stream_cipher.sv
`timescale 1ns / 100ps

module tb_rc4_stream_cipher;
    import rc4_pkg::*;

    localparam logic [CMD_W-1:0] OP_UNUSED = 2'd3;
    localparam int PHASE_ITEMS  = 300;
    localparam int QUIET_CYCLES = 4000;
    localparam int HOLD_CYCLES  = 3000;
    localparam int TAIL_CYCLES  = 200;
    localparam int CYCLE_LIMIT  = 1500000;

    class rc4_cipher_scoreboard;
        bit [BYTE_W-1:0] key_mem [SBOX_DEPTH];
        bit [BYTE_W-1:0] sbox [SBOX_DEPTH];
        bit [BYTE_W-1:0] pos_i;
        bit [BYTE_W-1:0] pos_j;
        bit [LEN_W-1:0]  key_len;
        bit [BYTE_W-1:0] expected_text [$];
        int errors;
        int checked;
        int schedules;

        function new();
            key_len   = KEY_LEN_RST;
            pos_i     = '0;
            pos_j     = '0;
            errors    = 0;
            checked   = 0;
            schedules = 0;
        endfunction

        function void set_key_length(bit [LEN_W-1:0] value);
            key_len = value;
        endfunction

        function int effective_length();
            int n;
            n = key_len;
            if (n == 0) n = 1;
            if (n > KEY_DEPTH_DEF) n = KEY_DEPTH_DEF;
            return n;
        endfunction

        function int pending();
            return expected_text.size();
        endfunction

        function void schedule_keys();
            int len;
            int kpos;
            bit [BYTE_W-1:0] jj;
            bit [BYTE_W-1:0] t;
            len  = effective_length();
            kpos = 0;
            jj   = '0;
            for (int n = 0; n < SBOX_DEPTH; n++) sbox[n] = BYTE_W'(n);
            for (int n = 0; n < SBOX_DEPTH; n++) begin
                jj = jj + sbox[n] + key_mem[kpos];
                t = sbox[n];
                sbox[n] = sbox[jj];
                sbox[jj] = t;
                kpos++;
                if (kpos >= len) kpos = 0;
            end
            pos_i = '0;
            pos_j = '0;
            schedules++;
        endfunction

        function void note_beat(bit [CMD_W-1:0] cmd, bit [BYTE_W-1:0] kidx,
                                bit [BYTE_W-1:0] data);
            bit [BYTE_W-1:0] t;
            bit [BYTE_W-1:0] ks_pos;
            case (cmd)
                OP_LOAD: key_mem[kidx] = data;
                OP_BEGIN: schedule_keys();
                OP_CRYPT: begin
                    pos_i = pos_i + 8'd1;
                    pos_j = pos_j + sbox[pos_i];
                    t = sbox[pos_i];
                    sbox[pos_i] = sbox[pos_j];
                    sbox[pos_j] = t;
                    ks_pos = sbox[pos_i] + sbox[pos_j];
                    expected_text.push_back(data ^ sbox[ks_pos]);
                end
                default: ;
            endcase
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch at %0t: %s", $time, msg);
        endtask

        task check_beat(logic [BYTE_W-1:0] got);
            bit [BYTE_W-1:0] want;
            if (expected_text.size() == 0) begin
                report($sformatf("out_byte %02h with nothing expected", got));
                return;
            end
            want = expected_text.pop_front();
            checked++;
            if (got !== want)
                report($sformatf("out_byte %02h, expected %02h", got, want));
        endtask

        task drain_check();
            if (expected_text.size() != 0)
                report($sformatf("%0d out_byte beats never arrived", expected_text.size()));
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [2*BYTE_W-1:0]    s_axis_tdata = '0;   // key_index, data_byte
    logic [CMD_W-1:0]       s_axis_tuser = '0;   // cmd
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [BYTE_W-1:0]      m_axis_tdata;        // out_byte
    logic                   i_cfg_we = 1'b0;
    logic [LEN_W-1:0]       i_cfg_wdata = '0;

    rc4_cipher_scoreboard sb;
    bit key_written [SBOX_DEPTH];
    int items_sent = 0;
    int tx_gap_pct = 0;
    int rx_stall_pct = 0;
    int rx_stall_left = 0;
    bit rx_hold = 1'b0;
    bit hold_start = 1'b0;
    bit squeeze_done = 1'b0;
    int cycle_count = 0;

    rc4_stream_cipher DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 10;
            2: return 35;
            default: return 70;
        endcase
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata);
        if (rx_hold || rx_stall_left > 0) begin
            m_axis_tready <= 1'b0;
            if (rx_stall_left > 0) rx_stall_left <= rx_stall_left - 1;
        end else if ($urandom_range(0, 99) < rx_stall_pct) begin
            m_axis_tready <= 1'b0;
            rx_stall_left <= pick_gap() - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        wait (hold_start);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    task automatic send_item(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] kidx,
                             logic [BYTE_W-1:0] data);
        int gap;
        gap = ($urandom_range(0, 99) < tx_gap_pct) ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {data, kidx};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_beat(cmd, kidx, data);
        if (cmd != OP_UNUSED) items_sent++;
        if (cmd == OP_LOAD) key_written[kidx] = 1'b1;
    endtask

    task automatic configure(logic [LEN_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_key_length(value);
    endtask

    task automatic run_message(bit squeeze);
        int eff;
        int n_crypt;
        int r;
        eff = sb.effective_length();
        tx_gap_pct = pick_pct();
        rx_stall_pct <= pick_pct();
        for (int k = 0; k < eff; k++)
            if (!key_written[k]) send_item(OP_LOAD, BYTE_W'(k), BYTE_W'($urandom));
        repeat ($urandom_range(0, 4))
            send_item(OP_LOAD, BYTE_W'($urandom_range(0, eff - 1)), BYTE_W'($urandom));
        if ($urandom_range(0, 9) == 0)
            send_item(OP_LOAD, BYTE_W'($urandom), BYTE_W'($urandom));
        if ($urandom_range(0, 9) == 0)
            send_item(OP_UNUSED, BYTE_W'($urandom), BYTE_W'($urandom));
        send_item(OP_BEGIN, BYTE_W'($urandom), BYTE_W'($urandom));
        if ($urandom_range(0, 9) == 0)
            send_item(OP_BEGIN, BYTE_W'($urandom), BYTE_W'($urandom));
        r = $urandom_range(0, 99);
        if (r < 8)       n_crypt = 0;
        else if (r < 75) n_crypt = $urandom_range(1, 24);
        else if (r < 97) n_crypt = $urandom_range(25, 80);
        else             n_crypt = $urandom_range(250, 300);
        if (squeeze) begin
            send_item(OP_CRYPT, BYTE_W'($urandom), BYTE_W'($urandom));
            hold_start <= 1'b1;
            n_crypt = 60;
        end
        for (int c = 0; c < n_crypt; c++) begin
            r = $urandom_range(0, 99);
            if (r < 4)      send_item(OP_UNUSED, BYTE_W'($urandom), BYTE_W'($urandom));
            else if (r < 7) send_item(OP_LOAD, BYTE_W'($urandom), BYTE_W'($urandom));
            send_item(OP_CRYPT, BYTE_W'($urandom), BYTE_W'($urandom));
        end
    endtask

    initial begin
        logic [LEN_W-1:0] phase_len [6];
        logic [BYTE_W-1:0] first_text [6];
        first_text = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80};
        phase_len  = '{9'd1, 9'd0, 9'd256, 9'd2, 9'd511, 9'd3};
        phase_len[5] = LEN_W'($urandom_range(3, 255));
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        configure(phase_len[0]);
        send_item(OP_LOAD, 8'h00, 8'hFF);
        send_item(OP_LOAD, 8'hFF, 8'h00);
        send_item(OP_UNUSED, 8'hFF, 8'hFF);
        send_item(OP_BEGIN, 8'hFF, 8'hFF);
        foreach (first_text[n]) send_item(OP_CRYPT, 8'hFF, first_text[n]);
        send_item(OP_LOAD, 8'h00, 8'h00);
        send_item(OP_BEGIN, 8'h00, 8'h00);
        send_item(OP_BEGIN, 8'h00, 8'h00);
        send_item(OP_CRYPT, 8'h00, 8'h00);
        send_item(OP_CRYPT, 8'h00, 8'hFF);
        send_item(OP_UNUSED, 8'h00, 8'h00);
        send_item(OP_LOAD, 8'h80, 8'h7F);
        send_item(OP_CRYPT, 8'h55, 8'h7F);
        send_item(OP_BEGIN, 8'hAA, 8'h55);
        send_item(OP_CRYPT, 8'hAA, 8'hFF);
        send_item(OP_CRYPT, 8'h55, 8'h00);

        for (int p = 0; p < 6; p++) begin
            if (p > 0) configure(phase_len[p]);
            while (items_sent < (p + 1) * PHASE_ITEMS || (p == 3 && !squeeze_done)) begin
                run_message(p == 3 && !squeeze_done);
                if (p == 3) squeeze_done = 1'b1;
            end
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        sb.drain_check();
        $display("sent %0d beats: %0d key schedules, %0d cipher bytes compared",
                 items_sent, sb.schedules, sb.checked);
        $display("key lengths written: 1, 0, 256, 2, 511 and %0d; one long output stall",
                 phase_len[5]);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
